>>> sv/oal_pkg.sv
// Shared types, codes and constants for the ordered array list.
`default_nettype none

package oal_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_WIDTH   = 32;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      mode_type                      mode;
      logic [3:0]                    position;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      status_type                    status;
      logic signed [VALUE_WIDTH-1:0] removed_value;
      logic                          found;
      logic [3:0]                    found_index;
      logic [4:0]                    entry_count;
      logic                          is_full;
      logic                          is_empty;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_INS_READ,
      S_INS_MOVE,
      S_INS_WRITE,
      S_DEL_CAP,
      S_DEL_READ,
      S_DEL_MOVE,
      S_SRCH_READ,
      S_SRCH_CMP,
      S_DONE
   } state_type;

   // read address source
   typedef enum logic [1:0] {
      RD_POS,
      RD_IDX,
      RD_IDX_M1,
      RD_IDX_P1
   } rd_sel_type;

   // walking index update
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_COUNT,
      IDX_POS,
      IDX_ZERO,
      IDX_DEC,
      IDX_INC
   } idx_op_type;

   typedef struct packed {
      logic       load_req;
      idx_op_type idx_op;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       wr_new;
      logic       take_removed;
      logic       take_hit;
      logic       set_status;
      status_type status_code;
      logic       count_inc;
      logic       count_dec;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     full;
      logic     empty;
      logic     pos_gt_count;
      logic     pos_ge_count;
      logic     idx_gt_pos1;
      logic     idx_p1_lt_count;
      logic     idx_p2_lt_count;
      logic     match;
   } dp_status_type;

endpackage

`default_nettype wire

>>> sv/oal_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module oal_ram #(
   parameter int WIDTH = oal_pkg::VALUE_WIDTH,
   parameter int DEPTH = oal_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/oal_datapath.sv
// Datapath: request hold, entry count, walking index, entry RAM and result registers.
`default_nettype none

module oal_datapath #(
   parameter int DEPTH = oal_pkg::DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire oal_pkg::req_type      req_data,
   input  wire oal_pkg::cmd_type      cmd,
   output oal_pkg::dp_status_type     stat,
   output oal_pkg::rsp_type           rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (CW > 4) ? CW : 4;
   localparam int OW = (CW > 5) ? CW : 5;
   localparam logic [IW:0] ONE_X = (IW + 1)'(1);
   localparam logic [IW:0] TWO_X = (IW + 1)'(2);

   oal_pkg::req_type                      req_ff;
   logic [CW-1:0]                         count_ff, count_in;
   logic [AW-1:0]                         idx_ff, idx_in;
   oal_pkg::status_type                   status_ff;
   logic signed [oal_pkg::VALUE_WIDTH-1:0] removed_ff;
   logic                                  found_ff;
   logic [AW-1:0]                         found_idx_ff;

   logic [oal_pkg::VALUE_WIDTH-1:0] rd_data;
   logic [oal_pkg::VALUE_WIDTH-1:0] wr_data;
   logic [AW-1:0]                   rd_addr;
   logic [AW-1:0]                   wr_addr;
   logic [AW-1:0]                   pos_a;
   logic [IW:0]                     cnt_x, pos_x, idx_x;
   logic [OW-1:0]                   cnt_o;
   logic [IW-1:0]                   fidx_o;

   assign cnt_x = (IW + 1)'(count_ff);
   assign pos_x = (IW + 1)'(req_ff.position);
   assign idx_x = (IW + 1)'(idx_ff);
   assign pos_a = pos_x[AW-1:0];

   always_comb begin
      case (cmd.rd_sel)
         oal_pkg::RD_POS:    rd_addr = pos_a;
         oal_pkg::RD_IDX:    rd_addr = idx_ff;
         oal_pkg::RD_IDX_M1: rd_addr = idx_ff - AW'(1);
         oal_pkg::RD_IDX_P1: rd_addr = idx_ff + AW'(1);
         default:            rd_addr = idx_ff;
      endcase
   end

   // new value lands at the position, shifted entries move to the index
   assign wr_addr = cmd.wr_new ? pos_a : idx_ff;
   assign wr_data = cmd.wr_new ? $unsigned(req_ff.value) : rd_data;

   oal_ram #(
      .WIDTH (oal_pkg::VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      unique case (cmd.idx_op)
         oal_pkg::IDX_HOLD:  idx_in = idx_ff;
         oal_pkg::IDX_COUNT: idx_in = count_ff[AW-1:0];
         oal_pkg::IDX_POS:   idx_in = pos_a;
         oal_pkg::IDX_ZERO:  idx_in = '0;
         oal_pkg::IDX_DEC:   idx_in = idx_ff - AW'(1);
         oal_pkg::IDX_INC:   idx_in = idx_ff + AW'(1);
         default:            idx_in = idx_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         req_ff       <= req_data;
         status_ff    <= oal_pkg::ST_OK;
         removed_ff   <= '0;
         found_ff     <= 1'b0;
         found_idx_ff <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.take_removed) begin
            removed_ff <= $signed(rd_data);
         end
         if (cmd.take_hit) begin
            found_ff     <= 1'b1;
            found_idx_ff <= idx_ff;
         end
      end
   end

   always_comb begin
      stat.mode            = req_ff.mode;
      stat.full            = (count_ff == CW'(DEPTH));
      stat.empty           = (count_ff == '0);
      stat.pos_gt_count    = (pos_x > cnt_x);
      stat.pos_ge_count    = (pos_x >= cnt_x);
      stat.idx_gt_pos1     = (idx_x > (pos_x + ONE_X));
      stat.idx_p1_lt_count = ((idx_x + ONE_X) < cnt_x);
      stat.idx_p2_lt_count = ((idx_x + TWO_X) < cnt_x);
      stat.match           = (rd_data == $unsigned(req_ff.value));
   end

   assign cnt_o  = OW'(count_ff);
   assign fidx_o = IW'(found_idx_ff);

   always_comb begin
      rsp_data.status        = status_ff;
      rsp_data.removed_value = removed_ff;
      rsp_data.found         = found_ff;
      rsp_data.found_index   = fidx_o[3:0];
      rsp_data.entry_count   = cnt_o[4:0];
      rsp_data.is_full       = (count_ff == CW'(DEPTH));
      rsp_data.is_empty      = (count_ff == '0);
   end

endmodule

`default_nettype wire

>>> sv/oal_controller.sv
// Controller: sequences checks, entry shifts and the search scan.
`default_nettype none

module oal_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output logic                       rsp_valid,
   input  wire oal_pkg::dp_status_type stat,
   output oal_pkg::cmd_type           cmd
);

   oal_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oal_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      cmd.load_req     = 1'b0;
      cmd.idx_op       = oal_pkg::IDX_HOLD;
      cmd.rd_en        = 1'b0;
      cmd.rd_sel       = oal_pkg::RD_IDX;
      cmd.wr_en        = 1'b0;
      cmd.wr_new       = 1'b0;
      cmd.take_removed = 1'b0;
      cmd.take_hit     = 1'b0;
      cmd.set_status   = 1'b0;
      cmd.status_code  = oal_pkg::ST_OK;
      cmd.count_inc    = 1'b0;
      cmd.count_dec    = 1'b0;
      busy             = (state_ff != oal_pkg::S_IDLE);
      rsp_valid        = 1'b0;

      unique case (state_ff)
         oal_pkg::S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = oal_pkg::S_CHECK;
            end
         end

         oal_pkg::S_CHECK: begin
            unique case (stat.mode)
               oal_pkg::MODE_INSERT: begin
                  if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = oal_pkg::ST_FULL;
                     state_in        = oal_pkg::S_DONE;
                  end else if (stat.pos_gt_count) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = oal_pkg::ST_RANGE;
                     state_in        = oal_pkg::S_DONE;
                  end else if (!stat.pos_ge_count) begin
                     cmd.idx_op = oal_pkg::IDX_COUNT;
                     state_in   = oal_pkg::S_INS_READ;
                  end else begin
                     state_in = oal_pkg::S_INS_WRITE;
                  end
               end
               oal_pkg::MODE_DELETE: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = oal_pkg::ST_EMPTY;
                     state_in        = oal_pkg::S_DONE;
                  end else if (stat.pos_ge_count) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = oal_pkg::ST_RANGE;
                     state_in        = oal_pkg::S_DONE;
                  end else begin
                     cmd.idx_op = oal_pkg::IDX_POS;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = oal_pkg::RD_POS;
                     state_in   = oal_pkg::S_DEL_CAP;
                  end
               end
               oal_pkg::MODE_SEARCH: begin
                  if (stat.empty) begin
                     state_in = oal_pkg::S_DONE;
                  end else begin
                     cmd.idx_op = oal_pkg::IDX_ZERO;
                     state_in   = oal_pkg::S_SRCH_READ;
                  end
               end
               oal_pkg::MODE_QUERY: begin
                  state_in = oal_pkg::S_DONE;
               end
               default: begin
                  state_in = oal_pkg::S_DONE;
               end
            endcase
         end

         // shift up: copy entry idx-1 into idx, walking down to the position
         oal_pkg::S_INS_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = oal_pkg::RD_IDX_M1;
            state_in   = oal_pkg::S_INS_MOVE;
         end

         oal_pkg::S_INS_MOVE: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = oal_pkg::IDX_DEC;
            state_in   = stat.idx_gt_pos1 ? oal_pkg::S_INS_READ : oal_pkg::S_INS_WRITE;
         end

         oal_pkg::S_INS_WRITE: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_new    = 1'b1;
            cmd.count_inc = 1'b1;
            state_in      = oal_pkg::S_DONE;
         end

         oal_pkg::S_DEL_CAP: begin
            cmd.take_removed = 1'b1;
            if (stat.idx_p1_lt_count) begin
               state_in = oal_pkg::S_DEL_READ;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = oal_pkg::S_DONE;
            end
         end

         // shift down: copy entry idx+1 into idx
         oal_pkg::S_DEL_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = oal_pkg::RD_IDX_P1;
            state_in   = oal_pkg::S_DEL_MOVE;
         end

         oal_pkg::S_DEL_MOVE: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = oal_pkg::IDX_INC;
            if (stat.idx_p2_lt_count) begin
               state_in = oal_pkg::S_DEL_READ;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = oal_pkg::S_DONE;
            end
         end

         oal_pkg::S_SRCH_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = oal_pkg::RD_IDX;
            state_in   = oal_pkg::S_SRCH_CMP;
         end

         oal_pkg::S_SRCH_CMP: begin
            if (stat.match) begin
               cmd.take_hit = 1'b1;
               state_in     = oal_pkg::S_DONE;
            end else if (stat.idx_p1_lt_count) begin
               cmd.idx_op = oal_pkg::IDX_INC;
               state_in   = oal_pkg::S_SRCH_READ;
            end else begin
               state_in = oal_pkg::S_DONE;
            end
         end

         oal_pkg::S_DONE: begin
            rsp_valid = 1'b1;
            state_in  = oal_pkg::S_IDLE;
         end

         default: begin
            state_in = oal_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> sv/ordered_array_list_top.sv
// Ordered array list: insert, delete and search over a RAM of signed words.
// Insert shifts entries from the position up, then writes the new value; delete captures
// the entry at the position and shifts those above it down; search scans from index 0 to a
// hit or the end; rejected operations and queries go straight to the result beat.
// Busy stays high through the result beat, and no new item is taken while busy.
// Reset empties the list; entry contents are left as they are and never read before written.
`default_nettype none

module ordered_array_list_top #(
   parameter int DEPTH = oal_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire oal_pkg::req_type req_data,
   output logic                  rsp_valid,
   output oal_pkg::rsp_type      rsp_data
);

   oal_pkg::cmd_type       cmd;
   oal_pkg::dp_status_type stat;

   oal_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   oal_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // an accepted item keeps the block busy
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // one result beat per item
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("back-to-back result beats");

   // a rejected operation removes and finds nothing
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != oal_pkg::ST_OK)
         |-> (rsp_data.removed_value == '0 && !rsp_data.found))
      else $error("rejected operation reports data");

   // a hit only comes from a search
   assert property (@(posedge clock) disable iff (reset)
      (cmd.take_hit) |-> (stat.mode == oal_pkg::MODE_SEARCH && !stat.empty))
      else $error("hit outside a search");

   // the list is never both full and empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_full && rsp_data.is_empty))
      else $error("full and empty together");

endmodule

`default_nettype wire
